// ===== hw/rtl/ut2cal_pkg.sv =====
// ============================================================================
// ut2cal_pkg - constants for the seconds-to-calendar converter
// Divider reciprocals, calendar anchors and the March-based month table.
// ============================================================================
package ut2cal_pkg;

  // Pipeline depth of the converter
  localparam int unsigned NUM_STAGES = 10;

  // Time-of-day divisors
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Floor reciprocals; each quotient is at most one short and is corrected
  // by a single compare and subtract
  localparam logic [25:0] DAY_RECIP  = 26'd50903316; // 2^35 / 675, input >> 7
  localparam int unsigned DAY_SHIFT  = 35;
  localparam logic [16:0] HOUR_RECIP = 17'd74565;    // 2^28 / 3600
  localparam logic [12:0] MIN_RECIP  = 13'd4369;     // 2^18 / 60
  localparam logic [16:0] WEEK_RECIP = 17'd74898;    // 2^19 / 7
  localparam logic [15:0] CYC_RECIP  = 16'd45933;    // 2^26 / 1461

  // Day counts
  localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;

  // Days are counted from 1968-03-01, the start of a four-year cycle
  localparam logic [9:0]  DAYS_TO_EPOCH  = 10'd671;
  // Day index of 1 March 2100 in the real calendar; from there on, add one
  // to skip the leap day that 2100 does not have
  localparam logic [15:0] SKIP_2100      = 16'd48212;
  localparam logic [11:0] YEAR_BASE      = 12'd1968;

  // Output ranges
  localparam logic [11:0] YEAR_MIN = 12'd1970;
  localparam logic [11:0] YEAR_MAX = 12'd2106;

  // Month numbers
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Index of January in the March-based year
  localparam logic [3:0] MIDX_JAN = 4'd10;
  localparam logic [3:0] MIDX_MAX = 4'd11;

  // First day of each month within a year that starts on 1 March
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] s;
    begin
      case (idx)
        4'd0:    s = 9'd0;
        4'd1:    s = 9'd31;
        4'd2:    s = 9'd61;
        4'd3:    s = 9'd92;
        4'd4:    s = 9'd122;
        4'd5:    s = 9'd153;
        4'd6:    s = 9'd184;
        4'd7:    s = 9'd214;
        4'd8:    s = 9'd245;
        4'd9:    s = 9'd275;
        4'd10:   s = 9'd306;
        4'd11:   s = 9'd337;
        default: s = 9'd0;
      endcase
      return s;
    end
  endfunction

endpackage

// ===== hw/rtl/unix_time_to_calendar.sv =====
// ============================================================================
// unix_time_to_calendar - Unix seconds to Gregorian date and time
// Ten-stage pipeline: constant dividers by reciprocal multiply, then a
// four-year-cycle decomposition of the day count.
// ============================================================================
// The block takes one request per clock while in_stall is low. Each request
// passes through the ten register stages of the pipeline, stage 0 to
// stage 9, and results leave in request order. Every 32-bit input is valid,
// up to 2106-02-07 06:28:15.
// A stall on the output holds the last stage, and the hold ripples back only
// through stages that carry a valid request, so bubbles are squeezed out and
// the input is stalled only when the whole pipeline is full and blocked.
// The block keeps no state between requests and has no registers to set.
module unix_time_to_calendar
  import ut2cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] seconds_since_epoch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday
);

  // --------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or the stage after it moves on
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: estimate days = t / 86400 as (t >> 7) / 675
  // --------------------------------------------------------------------------
  logic [31:0] s0_t;
  logic [50:0] s0_pd;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_t  <= seconds_since_epoch;
      s0_pd <= 51'(seconds_since_epoch[31:7]) * 51'(DAY_RECIP);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: multiply the estimate back out
  // --------------------------------------------------------------------------
  logic [31:0] s1_t;
  logic [15:0] s1_q;
  logic [32:0] s1_pm;
  logic [15:0] s1_q_next;

  assign s1_q_next = s0_pd[DAY_SHIFT+15:DAY_SHIFT];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_t  <= s0_t;
      s1_q  <= s1_q_next;
      s1_pm <= 33'(s1_q_next) * 33'(SECS_PER_DAY);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: correct the day count; keep the seconds of the day
  // --------------------------------------------------------------------------
  logic [15:0] s2_days;
  logic [16:0] s2_rem;
  logic [32:0] s2_diff;
  logic [17:0] s2_r0;

  assign s2_diff = {1'b0, s1_t} - s1_pm;
  assign s2_r0   = s2_diff[17:0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (s2_r0 >= 18'(SECS_PER_DAY)) begin
        s2_days <= s1_q + 16'd1;
        s2_rem  <= 17'(s2_r0 - 18'(SECS_PER_DAY));
      end else begin
        s2_days <= s1_q;
        s2_rem  <= s2_r0[16:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: rebase the day count to 1968-03-01 and skip 29 Feb 2100
  // --------------------------------------------------------------------------
  logic [16:0] s3_v;
  logic [15:0] s3_dj;
  logic [16:0] s3_rem;
  logic [15:0] s3_shift;

  assign s3_shift = s2_days + 16'(DAYS_TO_EPOCH);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_v   <= 17'(s2_days) + 17'(EPOCH_WEEKDAY);
      s3_dj  <= (s3_shift >= SKIP_2100) ? s3_shift + 16'd1 : s3_shift;
      s3_rem <= s2_rem;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: reciprocal products for hour, weekday and four-year cycle
  // --------------------------------------------------------------------------
  logic [33:0] s4_ph;
  logic [31:0] s4_pw;
  logic [31:0] s4_pc;
  logic [16:0] s4_rem;
  logic [16:0] s4_v;
  logic [15:0] s4_dj;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_ph  <= 34'(s3_rem) * 34'(HOUR_RECIP);
      s4_pw  <= 32'(s3_v) * 32'(WEEK_RECIP);
      s4_pc  <= 32'(s3_dj) * 32'(CYC_RECIP);
      s4_rem <= s3_rem;
      s4_v   <= s3_v;
      s4_dj  <= s3_dj;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: multiply the quotient estimates back out
  // --------------------------------------------------------------------------
  logic [4:0]  s5_h;
  logic [5:0]  s5_c;
  logic [16:0] s5_hp;
  logic [16:0] s5_wp;
  logic [15:0] s5_cp;
  logic [16:0] s5_rem;
  logic [16:0] s5_v;
  logic [15:0] s5_dj;
  logic [4:0]  s5_h_next;
  logic [12:0] s5_w_next;
  logic [5:0]  s5_c_next;

  assign s5_h_next = s4_ph[32:28];
  assign s5_w_next = s4_pw[31:19];
  assign s5_c_next = s4_pc[31:26];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_h   <= s5_h_next;
      s5_c   <= s5_c_next;
      s5_hp  <= 17'(s5_h_next) * 17'(SECS_PER_HOUR);
      s5_wp  <= 17'(s5_w_next) * 17'(DAYS_PER_WEEK);
      s5_cp  <= 16'(s5_c_next) * 16'(DAYS_PER_CYCLE);
      s5_rem <= s4_rem;
      s5_v   <= s4_v;
      s5_dj  <= s4_dj;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: correct hour, weekday and cycle; keep the remainders
  // --------------------------------------------------------------------------
  logic [4:0]  s6_hour;
  logic [11:0] s6_r2;
  logic [2:0]  s6_wd;
  logic [5:0]  s6_cyc;
  logic [10:0] s6_doc;
  logic [16:0] s6_rh_full;
  logic [12:0] s6_rh;
  logic [16:0] s6_rw_full;
  logic [3:0]  s6_rw;
  logic [15:0] s6_rc_full;
  logic [11:0] s6_rc;

  assign s6_rh_full = s5_rem - s5_hp;
  assign s6_rh      = s6_rh_full[12:0];
  assign s6_rw_full = s5_v - s5_wp;
  assign s6_rw      = s6_rw_full[3:0];
  assign s6_rc_full = s5_dj - s5_cp;
  assign s6_rc      = s6_rc_full[11:0];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (s6_rh >= 13'(SECS_PER_HOUR)) begin
        s6_hour <= s5_h + 5'd1;
        s6_r2   <= 12'(s6_rh - 13'(SECS_PER_HOUR));
      end else begin
        s6_hour <= s5_h;
        s6_r2   <= s6_rh[11:0];
      end
      if (s6_rw >= 4'(DAYS_PER_WEEK)) begin
        s6_wd <= 3'(s6_rw - 4'(DAYS_PER_WEEK));
      end else begin
        s6_wd <= s6_rw[2:0];
      end
      if (s6_rc >= 12'(DAYS_PER_CYCLE)) begin
        s6_cyc <= s5_c + 6'd1;
        s6_doc <= 11'(s6_rc - 12'(DAYS_PER_CYCLE));
      end else begin
        s6_cyc <= s5_c;
        s6_doc <= s6_rc[10:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: year within the cycle; minute estimate
  // --------------------------------------------------------------------------
  logic [23:0] s7_pmin;
  logic [8:0]  s7_doy;
  logic [11:0] s7_yb;
  logic [4:0]  s7_hour;
  logic [2:0]  s7_wd;
  logic [11:0] s7_r2;
  logic [1:0]  s7_yoc;
  logic [10:0] s7_doy_full;

  // The last day of a cycle is 29 February and stays in the fourth year
  always_comb begin
    s7_yoc = 2'd0;
    if (s6_doc >= 11'(DAYS_PER_YEAR)) begin
      s7_yoc = 2'd1;
    end
    if (s6_doc >= 11'(2 * DAYS_PER_YEAR)) begin
      s7_yoc = 2'd2;
    end
    if (s6_doc >= 11'(3 * DAYS_PER_YEAR)) begin
      s7_yoc = 2'd3;
    end
  end

  assign s7_doy_full = s6_doc - 11'(s7_yoc) * 11'(DAYS_PER_YEAR);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_pmin <= 24'(s6_r2) * 24'(MIN_RECIP);
      s7_doy  <= s7_doy_full[8:0];
      s7_yb   <= YEAR_BASE + 12'({s6_cyc, 2'b00}) + 12'(s7_yoc);
      s7_hour <= s6_hour;
      s7_wd   <= s6_wd;
      s7_r2   <= s6_r2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: month of the March-based year; minute product
  // --------------------------------------------------------------------------
  logic [3:0]  s8_midx;
  logic [8:0]  s8_doy;
  logic [11:0] s8_yb;
  logic [5:0]  s8_m;
  logic [11:0] s8_mp;
  logic [11:0] s8_r2;
  logic [4:0]  s8_hour;
  logic [2:0]  s8_wd;
  logic [3:0]  s8_midx_next;
  logic [5:0]  s8_m_next;

  always_comb begin
    s8_midx_next = 4'd0;
    for (int i = 1; i <= 11; i++) begin
      if (s7_doy >= month_start(4'(i))) begin
        s8_midx_next = s8_midx_next + 4'd1;
      end
    end
  end

  assign s8_m_next = s7_pmin[23:18];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_midx <= s8_midx_next;
      s8_doy  <= s7_doy;
      s8_yb   <= s7_yb;
      s8_m    <= s8_m_next;
      s8_mp   <= 12'(s8_m_next) * 12'(SECS_PER_MIN);
      s8_r2   <= s7_r2;
      s8_hour <= s7_hour;
      s8_wd   <= s7_wd;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: output register; January and February roll into the next year
  // --------------------------------------------------------------------------
  logic [11:0] s9_sr;
  logic [8:0]  s9_dom;

  assign s9_sr  = s8_r2 - s8_mp;
  assign s9_dom = s8_doy - month_start(s8_midx);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      day     <= 5'(s9_dom + 9'd1);
      hour    <= s8_hour;
      weekday <= s8_wd;
      if (s8_midx >= MIDX_JAN) begin
        month <= s8_midx - (MIDX_JAN - MON_JAN);
        year  <= s8_yb + 12'd1;
      end else begin
        month <= s8_midx + (MON_DEC - MIDX_MAX) + 4'd2;
        year  <= s8_yb;
      end
      if (s9_sr >= 12'(SECS_PER_MIN)) begin
        minute <= s8_m + 6'd1;
        second <= 6'(s9_sr - 12'(SECS_PER_MIN));
      end else begin
        minute <= s8_m;
        second <= s9_sr[5:0];
      end
    end
  end

endmodule

// ===== hw/rtl/ut2cal_checker.sv =====
// ============================================================================
// ut2cal_checker - port-level checks for the calendar converter
// Watches held results, calendar consistency and the input stall.
// ============================================================================
module ut2cal_checker
  import ut2cal_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [2:0]  weekday
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
      && $stable(day) && $stable(hour) && $stable(minute) && $stable(second)
      && $stable(weekday))
    else $error("stalled result changed");

  // With no result waiting, the pipeline has room for a request
  a_free_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> year >= YEAR_MIN && year <= YEAR_MAX && month >= MON_JAN
      && month <= MON_DEC && day >= 5'd1 && day <= 5'd31 && hour <= 5'd23
      && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6)
    else $error("result field out of range");

  a_feb_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && month == MON_FEB |-> day <= 5'd29)
    else $error("February day too large");

  a_short_month: assert property (@(posedge clk) disable iff (rst)
    out_valid && (month == MON_APR || month == MON_JUN || month == MON_SEP
      || month == MON_NOV) |-> day <= 5'd30)
    else $error("day too large for a thirty-day month");

endmodule

bind unix_time_to_calendar ut2cal_checker u_ut2cal_checker (.*);
